// ===== hw/rtl/srs_pkg.sv =====
package srs_pkg;

	// field widths of the item formats
	localparam int unsigned SAMPLE_W = 20;
	localparam int unsigned MAG_W    = 20;
	localparam int unsigned SQ_W     = 40;
	localparam int unsigned RMSE_W   = 21;
	localparam int unsigned PSUM_W   = 48;
	localparam int unsigned FSUM_W   = 64;
	localparam int unsigned FCNT_W   = 27;

	// saturation limits
	localparam logic [RMSE_W-1:0] RMSE_MAX = '1;
	localparam logic [FCNT_W-1:0] FCNT_MAX = '1;

	// shared divide / root unit operand widths
	localparam int unsigned OPA_W  = 64;
	localparam int unsigned OPB_W  = 27;
	localparam int unsigned REM_W  = 34;
	localparam int unsigned CNT_W  = 7;
	localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd64;
	localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd32;

	typedef enum logic {
		UOP_DIV  = 1'b0,
		UOP_SQRT = 1'b1
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// ===== hw/rtl/srs_iter_unit.sv =====
// one bit per cycle: restoring divide (64 steps) or digit-by-digit root (32 steps)
module srs_iter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srs_pkg::unit_ctl_t            ctl,
	input  logic [srs_pkg::OPA_W-1:0]     opa,
	input  logic [srs_pkg::OPB_W-1:0]     opb,
	output srs_pkg::unit_sts_t            sts,
	output logic [srs_pkg::OPA_W-1:0]     result
);

	logic                          busy_q;
	logic                          done_q;
	srs_pkg::unit_op_t             op_q;
	logic [srs_pkg::CNT_W-1:0]     cnt_q;
	logic [srs_pkg::OPA_W-1:0]     acc_q;
	logic [srs_pkg::REM_W-1:0]     rem_q;
	logic [srs_pkg::OPA_W-1:0]     res_q;
	logic [srs_pkg::OPB_W-1:0]     den_q;

	logic [srs_pkg::REM_W-1:0]     rem_sh;
	logic [srs_pkg::REM_W-1:0]     trial;
	logic [srs_pkg::REM_W:0]       diff;
	logic                          fits;
	logic [srs_pkg::OPA_W-1:0]     acc_next;

	// shifted partial remainder and trial subtrahend for the selected op
	always_comb begin
		unique case (op_q)
			srs_pkg::UOP_DIV: begin
				rem_sh   = {6'b0, rem_q[srs_pkg::OPB_W-1:0], acc_q[srs_pkg::OPA_W-1]};
				trial    = {7'b0, den_q};
				acc_next = {acc_q[srs_pkg::OPA_W-2:0], 1'b0};
			end
			srs_pkg::UOP_SQRT: begin
				rem_sh   = {rem_q[srs_pkg::REM_W-3:0], acc_q[srs_pkg::OPA_W-1 -: 2]};
				trial    = {res_q[srs_pkg::REM_W-3:0], 2'b01};
				acc_next = {acc_q[srs_pkg::OPA_W-3:0], 2'b00};
			end
			default: begin
				rem_sh   = '0;
				trial    = '0;
				acc_next = '0;
			end
		endcase
	end

	// shared subtractor
	assign diff = {1'b0, rem_sh} - {1'b0, trial};
	assign fits = ~diff[srs_pkg::REM_W];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 7'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q  <= ctl.op;
			acc_q <= opa;
			den_q <= opb;
			rem_q <= '0;
			res_q <= '0;
			cnt_q <= (ctl.op == srs_pkg::UOP_DIV) ? srs_pkg::DIV_STEPS : srs_pkg::SQRT_STEPS;
		end else if (busy_q) begin
			acc_q <= acc_next;
			rem_q <= fits ? diff[srs_pkg::REM_W-1:0] : rem_sh;
			res_q <= {res_q[srs_pkg::OPA_W-2:0], fits};
			cnt_q <= cnt_q - 7'd1;
		end
	end

	// an empty divisor gives zero
	assign result = (op_q == srs_pkg::UOP_DIV && den_q == '0) ? '0 : res_q;

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// ===== hw/rtl/spectral_pixel_rmse_stats_top.sv =====
// an item without the last-band mark passes capture, square and accumulate before the next is taken
// an item with the last-band mark adds one divide (64 steps) and one root (32 steps)
// in the shared iterative unit before its result is loaded into the output register;
// a frame end adds a frame divide and root; a result still held at the output delays the next one
// one item at a time; the result waits in an output register while the next item enters
// asynchronous active-low reset clears all sums, counts, the running maximum and valid
module spectral_pixel_rmse_stats_top #(
	parameter int unsigned MAX_BANDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // sample_ref [19:0], sample_cmp [39:20]
	input  logic        s_tlast,   // last_band
	input  logic [0:0]  s_tuser,   // last_pixel [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pixel_rmse [20:0], max_rmse [41:21], global_rmse [62:42]
	output logic        m_tlast    // frame_done
);

	localparam int unsigned BC_W = $clog2(MAX_BANDS + 1);
	localparam logic [BC_W-1:0] BANDS_LIM = BC_W'(MAX_BANDS);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_MUL   = 12'b0000_0000_0010,
		ST_ACC   = 12'b0000_0000_0100,
		ST_PDIV  = 12'b0000_0000_1000,
		ST_PDIVW = 12'b0000_0001_0000,
		ST_PSQ   = 12'b0000_0010_0000,
		ST_PSQW  = 12'b0000_0100_0000,
		ST_FDIV  = 12'b0000_1000_0000,
		ST_FDIVW = 12'b0001_0000_0000,
		ST_FSQ   = 12'b0010_0000_0000,
		ST_FSQW  = 12'b0100_0000_0000,
		ST_EMIT  = 12'b1000_0000_0000
	} state_t;

	state_t                          state_q;

	logic [srs_pkg::MAG_W-1:0]       mag_q;
	logic [srs_pkg::SQ_W-1:0]        sq_q;
	logic                            last_band_q;
	logic                            last_pixel_q;
	logic                            acc_en_q;

	logic [srs_pkg::PSUM_W-1:0]      pixel_sum_q;
	logic [BC_W-1:0]                 band_count_q;
	logic [srs_pkg::FSUM_W-1:0]      frame_sum_q;
	logic [srs_pkg::FCNT_W-1:0]      frame_samples_q;
	logic [srs_pkg::RMSE_W-1:0]      running_max_q;
	logic [srs_pkg::RMSE_W-1:0]      prmse_q;
	logic [srs_pkg::RMSE_W-1:0]      grmse_q;

	logic                            m_tvalid_q;
	logic [63:0]                     m_tdata_q;
	logic                            m_tlast_q;

	logic signed [srs_pkg::SAMPLE_W:0] diff_in;
	logic [srs_pkg::SAMPLE_W:0]        abs_in;
	logic [srs_pkg::FSUM_W:0]          fsum_add;
	logic [srs_pkg::RMSE_W-1:0]        root_sat;
	logic                              out_free;

	srs_pkg::unit_ctl_t              u_ctl;
	srs_pkg::unit_sts_t              u_sts;
	logic [srs_pkg::OPA_W-1:0]       u_opa;
	logic [srs_pkg::OPB_W-1:0]       u_opb;
	logic [srs_pkg::OPA_W-1:0]       u_result;

	srs_iter_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (u_ctl),
		.opa    (u_opa),
		.opb    (u_opb),
		.sts    (u_sts),
		.result (u_result)
	);

	// difference magnitude of the incoming pair
	assign diff_in = $signed({s_tdata[19], s_tdata[19:0]}) - $signed({s_tdata[39], s_tdata[39:20]});
	assign abs_in  = diff_in[srs_pkg::SAMPLE_W] ? 21'(-diff_in) : 21'(diff_in);

	// saturating frame accumulate and root clamp
	assign fsum_add = {1'b0, frame_sum_q} + {25'b0, sq_q};
	assign root_sat = (|u_result[srs_pkg::OPA_W-1:srs_pkg::RMSE_W]) ? srs_pkg::RMSE_MAX
	                                                                 : u_result[srs_pkg::RMSE_W-1:0];
	assign out_free = ~m_tvalid_q | m_tready;

	// unit launch
	always_comb begin
		u_ctl.start = 1'b0;
		u_ctl.op    = srs_pkg::UOP_DIV;
		u_opa       = u_result;
		u_opb       = {{(srs_pkg::OPB_W-BC_W){1'b0}}, band_count_q};
		unique case (state_q)
			ST_PDIV: begin
				u_ctl.start = 1'b1;
				u_opa       = {{(srs_pkg::OPA_W-srs_pkg::PSUM_W){1'b0}}, pixel_sum_q};
			end
			ST_FDIV: begin
				u_ctl.start = 1'b1;
				u_opa       = frame_sum_q;
				u_opb       = frame_samples_q;
			end
			ST_PSQ, ST_FSQ: begin
				u_ctl.start = 1'b1;
				u_ctl.op    = srs_pkg::UOP_SQRT;
			end
			default: begin
				u_ctl.start = 1'b0;
			end
		endcase
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			pixel_sum_q     <= '0;
			band_count_q    <= '0;
			frame_sum_q     <= '0;
			frame_samples_q <= '0;
			running_max_q   <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			// result valid: load on emit, drop on handshake
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (acc_en_q) begin
						pixel_sum_q  <= pixel_sum_q + {8'b0, sq_q};
						band_count_q <= band_count_q + 1'b1;
						frame_sum_q  <= fsum_add[srs_pkg::FSUM_W] ? '1
						                                          : fsum_add[srs_pkg::FSUM_W-1:0];
						if (frame_samples_q != srs_pkg::FCNT_MAX) begin
							frame_samples_q <= frame_samples_q + 1'b1;
						end
					end
					state_q <= last_band_q ? ST_PDIV : ST_IDLE;
				end
				ST_PDIV: state_q <= ST_PDIVW;
				ST_PDIVW: begin
					if (u_sts.done) begin
						state_q <= ST_PSQ;
					end
				end
				ST_PSQ: state_q <= ST_PSQW;
				ST_PSQW: begin
					if (u_sts.done) begin
						if (root_sat > running_max_q) begin
							running_max_q <= root_sat;
						end
						state_q <= last_pixel_q ? ST_FDIV : ST_EMIT;
					end
				end
				ST_FDIV: state_q <= ST_FDIVW;
				ST_FDIVW: begin
					if (u_sts.done) begin
						state_q <= ST_FSQ;
					end
				end
				ST_FSQ: state_q <= ST_FSQW;
				ST_FSQW: begin
					if (u_sts.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						pixel_sum_q  <= '0;
						band_count_q <= '0;
						if (last_pixel_q) begin
							frame_sum_q     <= '0;
							frame_samples_q <= '0;
							running_max_q   <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, square and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			mag_q        <= abs_in[srs_pkg::MAG_W-1:0];
			last_band_q  <= s_tlast;
			last_pixel_q <= s_tuser[0];
			acc_en_q     <= band_count_q < BANDS_LIM;
		end
		if (state_q == ST_MUL) begin
			sq_q <= mag_q * mag_q;
		end
		if (state_q == ST_PSQW && u_sts.done) begin
			prmse_q <= root_sat;
		end
		if (state_q == ST_PDIV) begin
			grmse_q <= '0;
		end
		if (state_q == ST_FSQW && u_sts.done) begin
			grmse_q <= root_sat;
		end
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= {1'b0, grmse_q, running_max_q, prmse_q};
			m_tlast_q <= last_pixel_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// widths and limits from the package
	localparam int unsigned SAMPLE_W = srs_pkg::SAMPLE_W;
	localparam int unsigned RMSE_W = srs_pkg::RMSE_W;
	localparam int unsigned PSUM_W = srs_pkg::PSUM_W;
	localparam int unsigned FSUM_W = srs_pkg::FSUM_W;
	localparam int unsigned FCNT_W = srs_pkg::FCNT_W;
	localparam logic [RMSE_W-1:0] RMSE_MAX = srs_pkg::RMSE_MAX;
	localparam logic [FCNT_W-1:0] FCNT_MAX = srs_pkg::FCNT_MAX;

	localparam int unsigned BAND_LIMIT = 64;
	localparam int unsigned RANDOM_ITEMS = 1500;
	localparam int unsigned CALM_ITEMS = 1300;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam longint unsigned CYCLE_LIMIT = 2_000_000;
	localparam int NUM_ROWS = 13;

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 20'sh7FFFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 20'sh80000;
	localparam logic signed [SAMPLE_W-1:0] SMP_ONE = 20'sd4096;
	localparam logic [RMSE_W-1:0] FULL_ROOT = 21'd1048575;
	localparam logic [RMSE_W-1:0] ONE_ROOT = 21'd4096;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] ref_smp;
		logic signed [SAMPLE_W-1:0] cmp_smp;
		logic                       last_band;
		logic                       last_pixel;
	} band_item_t;

	typedef struct packed {
		logic [RMSE_W-1:0] pixel_rmse;
		logic [RMSE_W-1:0] max_rmse;
		logic [RMSE_W-1:0] global_rmse;
		logic              frame_done;
	} rmse_result_t;

	// one directed row: the item is repeated, marks go on the final copy only
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] ref_smp;
		logic signed [SAMPLE_W-1:0] cmp_smp;
		int unsigned                reps;
		logic                       last_band;
		logic                       last_pixel;
		logic                       typed;
		logic [RMSE_W-1:0]          pixel_rmse;
		logic [RMSE_W-1:0]          max_rmse;
		logic [RMSE_W-1:0]          global_rmse;
		logic                       frame_done;
	} stim_row_t;

	stim_row_t directed_rows [NUM_ROWS] = '{
		// zero difference right after reset, frame of one pixel
		'{20'sd0, 20'sd0, 1, 1'b1, 1'b1, 1'b1, 21'd0, 21'd0, 21'd0, 1'b1},
		// largest positive and negative difference
		'{SMP_MAX, SMP_MIN, 1, 1'b1, 1'b0, 1'b1, FULL_ROOT, FULL_ROOT, 21'd0, 1'b0},
		'{SMP_MIN, SMP_MAX, 1, 1'b1, 1'b1, 1'b1, FULL_ROOT, FULL_ROOT, FULL_ROOT, 1'b1},
		// fill a pixel to the band limit, then a dropped band that finishes it
		'{SMP_ONE, 20'sd0, BAND_LIMIT, 1'b0, 1'b0, 1'b0, 21'd0, 21'd0, 21'd0, 1'b0},
		'{SMP_MAX, SMP_MIN, 1, 1'b1, 1'b1, 1'b1, ONE_ROOT, ONE_ROOT, ONE_ROOT, 1'b1},
		// last-pixel mark without last band is ignored
		'{20'sd0, -SMP_ONE, 1, 1'b0, 1'b0, 1'b0, 21'd0, 21'd0, 21'd0, 1'b0},
		'{20'sd0, 20'sd0, 1, 1'b0, 1'b1, 1'b0, 21'd0, 21'd0, 21'd0, 1'b0},
		'{20'sd12288, 20'sd0, 1, 1'b1, 1'b0, 1'b0, 21'd0, 21'd0, 21'd0, 1'b0},
		'{20'sd1, 20'sd0, 1, 1'b1, 1'b1, 1'b0, 21'd0, 21'd0, 21'd0, 1'b0},
		// several dropped bands at full difference
		'{SMP_MAX, SMP_MIN, 70, 1'b1, 1'b1, 1'b1, FULL_ROOT, FULL_ROOT, FULL_ROOT, 1'b1},
		// equal extremes give zero in a fresh frame
		'{SMP_MIN, SMP_MIN, 1, 1'b1, 1'b0, 1'b1, 21'd0, 21'd0, 21'd0, 1'b0},
		'{SMP_MAX, SMP_MAX, 1, 1'b1, 1'b0, 1'b1, 21'd0, 21'd0, 21'd0, 1'b0},
		'{-SMP_ONE, SMP_ONE, 1, 1'b1, 1'b1, 1'b0, 21'd0, 21'd0, 21'd0, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;     // sample_ref [19:0], sample_cmp [39:20]
	logic        s_tlast = 1'b0;   // last_band
	logic [0:0]  s_tuser = '0;     // last_pixel [0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;          // pixel_rmse [20:0], max_rmse [41:21], global_rmse [62:42]
	logic        m_tlast;          // frame_done

	// predictor state
	logic [PSUM_W-1:0] pixel_acc = '0;
	int unsigned       bands_held = 0;
	logic [FSUM_W-1:0] frame_acc = '0;
	logic [FCNT_W-1:0] frame_cnt = '0;
	logic [RMSE_W-1:0] peak_rmse = '0;

	rmse_result_t      rmse_expected [$];
	int unsigned       fail_count = 0;
	longint unsigned   cycle_count = 0;
	bit                calm = 1'b0;
	int unsigned       idle_odds = 3;
	int unsigned       stall_odds = 4;
	int unsigned       stall_left = 0;

	spectral_pixel_rmse_stats_top #(
		.MAX_BANDS(BAND_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// floor of the integer square root, digit by digit
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] rest;
		logic [63:0] probe;
		root = '0;
		rest = v;
		probe = 64'd1 << 62;
		while (probe > rest)
			probe >>= 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// floor root of the mean, clipped to the output range
	function automatic logic [RMSE_W-1:0] mean_root(input logic [63:0] total,
			input logic [63:0] n);
		logic [63:0] r;
		if (n == 0)
			return '0;
		r = int_sqrt(total / n);
		return (r > 64'(RMSE_MAX)) ? RMSE_MAX : r[RMSE_W-1:0];
	endfunction

	// accumulate one band item, return 1 when it finishes a pixel
	function automatic bit advance_stats(input band_item_t it, output rmse_result_t res);
		logic signed [SAMPLE_W:0] diff;
		logic [63:0]              mag;
		logic [63:0]              sq;
		res = '0;
		if (bands_held < BAND_LIMIT) begin
			diff = it.ref_smp - it.cmp_smp;
			mag = diff[SAMPLE_W] ? 64'(-diff) : 64'(diff);
			sq = mag * mag;
			pixel_acc += sq[PSUM_W-1:0];
			bands_held++;
			if (frame_acc > ~64'd0 - sq)
				frame_acc = '1;
			else
				frame_acc += sq;
			if (frame_cnt != FCNT_MAX)
				frame_cnt++;
		end
		if (!it.last_band)
			return 1'b0;

		res.pixel_rmse = mean_root(64'(pixel_acc), 64'(bands_held));
		if (res.pixel_rmse > peak_rmse)
			peak_rmse = res.pixel_rmse;
		res.max_rmse = peak_rmse;
		if (it.last_pixel)
			res.global_rmse = mean_root(frame_acc, 64'(frame_cnt));
		res.frame_done = it.last_pixel;

		pixel_acc = '0;
		bands_held = 0;
		if (it.last_pixel) begin
			frame_acc = '0;
			frame_cnt = '0;
			peak_rmse = '0;
		end
		return 1'b1;
	endfunction

	// compare one accepted result with the oldest pending one
	function automatic void check_result();
		rmse_result_t want;
		logic [RMSE_W-1:0] got_pixel;
		logic [RMSE_W-1:0] got_max;
		logic [RMSE_W-1:0] got_global;
		if (rmse_expected.size() == 0) begin
			$error("result with nothing pending: m_tdata %h m_tlast %b", m_tdata, m_tlast);
			fail_count++;
			return;
		end
		want = rmse_expected.pop_front();
		got_pixel = m_tdata[RMSE_W-1:0];
		got_max = m_tdata[2*RMSE_W-1:RMSE_W];
		got_global = m_tdata[3*RMSE_W-1:2*RMSE_W];
		if (got_pixel !== want.pixel_rmse) begin
			$error("pixel_rmse: expected %0d, got %0d", want.pixel_rmse, got_pixel);
			fail_count++;
		end
		if (got_max !== want.max_rmse) begin
			$error("max_rmse: expected %0d, got %0d", want.max_rmse, got_max);
			fail_count++;
		end
		if (got_global !== want.global_rmse) begin
			$error("global_rmse: expected %0d, got %0d", want.global_rmse, got_global);
			fail_count++;
		end
		if (m_tlast !== want.frame_done) begin
			$error("frame_done: expected %0b, got %0b", want.frame_done, m_tlast);
			fail_count++;
		end
	endfunction

	// result side: check at each handshake, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result();
		if (calm) begin
			stall_left = 0;
			m_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			stall_left = $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// present one item, wait for it to be taken, then maybe idle a while
	task automatic send_band(input band_item_t it, input bit use_typed,
			input rmse_result_t typed_res);
		rmse_result_t res;
		s_tvalid <= 1'b1;
		s_tdata <= {it.cmp_smp, it.ref_smp};
		s_tlast <= it.last_band;
		s_tuser <= it.last_pixel;
		do @(posedge clk); while (!s_tready);
		if (advance_stats(it, res))
			rmse_expected.push_back(use_typed ? typed_res : res);
		if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// walk the directed table
	task automatic run_directed();
		stim_row_t    row;
		band_item_t   it;
		rmse_result_t want;
		bit           final_copy;
		for (int r = 0; r < NUM_ROWS; r++) begin
			row = directed_rows[r];
			want = '{row.pixel_rmse, row.max_rmse, row.global_rmse, row.frame_done};
			for (int k = 0; k < row.reps; k++) begin
				final_copy = (k == row.reps - 1);
				it.ref_smp = row.ref_smp;
				it.cmp_smp = row.cmp_smp;
				it.last_band = final_copy & row.last_band;
				it.last_pixel = final_copy & row.last_pixel;
				send_band(it, row.typed && final_copy, want);
			end
		end
	endtask

	function automatic int unsigned pick_odds();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 2;
			2: return 5;
			default: return 12;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// random band samples, shaped per pixel
	function automatic band_item_t random_band(input int unsigned mode,
			input logic signed [SAMPLE_W-1:0] base);
		band_item_t it;
		it = '0;
		case (mode)
			0: begin
				it.ref_smp = SAMPLE_W'($urandom);
				it.cmp_smp = SAMPLE_W'($urandom);
			end
			1: begin
				// close spectra: small differences around a common level
				it.ref_smp = base + SAMPLE_W'($urandom_range(0, 1023));
				it.cmp_smp = it.ref_smp + SAMPLE_W'($urandom_range(0, 255)) - 20'sd128;
			end
			2: begin
				it.ref_smp = pick_extreme();
				it.cmp_smp = pick_extreme();
			end
			default: begin
				it.ref_smp = SAMPLE_W'($urandom);
				it.cmp_smp = base;
			end
		endcase
		return it;
	endfunction

	// random frames of random pixels, the tail without any idling
	task automatic run_random();
		band_item_t                 it;
		int unsigned                sent;
		int unsigned                pixels;
		int unsigned                bands;
		int unsigned                mode;
		logic signed [SAMPLE_W-1:0] base;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= CALM_ITEMS) begin
				calm = 1'b1;
			end else begin
				idle_odds = pick_odds();
				stall_odds = pick_odds();
			end
			pixels = $urandom_range(1, 6);
			for (int p = 0; p < pixels; p++) begin
				case ($urandom_range(0, 19))
					0: bands = $urandom_range(BAND_LIMIT + 1, BAND_LIMIT + 8);
					1, 2, 3: bands = $urandom_range(9, BAND_LIMIT);
					default: bands = $urandom_range(1, 8);
				endcase
				mode = $urandom_range(0, 3);
				base = SAMPLE_W'($urandom);
				for (int b = 0; b < bands; b++) begin
					it = random_band(mode, base);
					it.last_band = (b == bands - 1);
					// stray last-pixel marks on inner bands as noise
					it.last_pixel = it.last_band ? (p == pixels - 1)
						: ($urandom_range(0, 15) == 0);
					send_band(it, 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	// reset, stimulus, drain and verdict
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		s_tvalid <= 1'b0;
		while (rmse_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/srs_pkg.sv
hw/rtl/srs_iter_unit.sv
hw/rtl/spectral_pixel_rmse_stats_top.sv
test/testbench.sv
